[rtl/core/dtcc_pkg.sv]
`default_nettype none

package dtcc_pkg;

	// result codes carried on the output stream
	typedef enum logic [1:0] {
		STAT_INCOMPLETE = 2'd0,
		STAT_COMPLETE   = 2'd1,
		STAT_INVALID    = 2'd2
	} status_t;

	// deflate block types
	typedef enum logic [1:0] {
		BTYPE_STORED   = 2'd0,
		BTYPE_FIXED    = 2'd1,
		BTYPE_DYNAMIC  = 2'd2,
		BTYPE_RESERVED = 2'd3
	} btype_t;

	// controller states
	typedef enum logic [2:0] {
		CS_IDLE,
		CS_HDR,
		CS_STORED,
		CS_CODE,
		CS_LEN_EXT,
		CS_DIST,
		CS_DIST_EXT,
		CS_DONE
	} ctrl_state_t;

	// datapath operations
	typedef enum logic [2:0] {
		OP_NOP,
		OP_LOAD,
		OP_HDR,
		OP_CODE,
		OP_SKIP,
		OP_DIST
	} dp_op_t;

	// outcome of one literal/length code bit
	typedef enum logic [2:0] {
		SYM_NONE,
		SYM_LIT,
		SYM_EOB,
		SYM_LEN,
		SYM_BAD
	} sym_kind_t;

	localparam int TAIL_W  = 40;
	localparam int COUNT_W = 6;
	localparam int CODE_W  = 9;
	localparam int NB_W    = 4;
	localparam int EXT_W   = 4;

	localparam logic [COUNT_W-1:0] HDR_BITS    = 6'd3;
	localparam logic [COUNT_W-1:0] DIST_BITS   = 6'd5;
	localparam logic [COUNT_W-1:0] STORED_MIN  = 6'd32;
	localparam logic [NB_W-1:0]    NB_SHORT    = 4'd7;
	localparam logic [NB_W-1:0]    NB_MID      = 4'd8;
	localparam logic [NB_W-1:0]    NB_LONG     = 4'd9;
	localparam logic [6:0]         FIX7_MAX    = 7'h17;
	localparam logic [7:0]         LIT8_LO     = 8'h30;
	localparam logic [7:0]         LIT8_HI     = 8'hBF;
	localparam logic [7:0]         LEN8_LO     = 8'hC0;
	localparam logic [7:0]         LEN8_HI     = 8'hC7;
	localparam logic [8:0]         LIT9_LO     = 9'h190;
	localparam logic [4:0]         LEN8_IDX0   = 5'd23;
	localparam logic [4:0]         LEN_IDX_MAX = 5'd28;
	localparam logic [4:0]         DIST_MAX    = 5'd29;
	localparam logic [31:0]        STORED_EMPTY = 32'hFFFF0000;

	// controller to datapath
	typedef struct packed {
		dp_op_t  op;
		logic    res_we;
		status_t res;
		logic    out_load;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic      count_bad;
		logic      hdr_short;
		btype_t    btype;
		logic      bfinal;
		status_t   stored_res;
		logic      rem_zero;
		sym_kind_t sym;
		logic      ext_short;
		logic      dist_short;
		logic      dist_bad;
		logic      out_free;
	} dp_sts_t;

	// extra bits of a length symbol, by index from symbol 257
	function automatic logic [EXT_W-1:0] len_extra(input logic [4:0] idx);
		logic [4:0] t;
		t = idx - 5'd4;
		if (idx < 5'd8 || idx >= 5'd28)
			return '0;
		return {1'b0, t[4:2]};
	endfunction

	// extra bits of a distance code
	function automatic logic [EXT_W-1:0] dist_extra(input logic [4:0] d);
		if (d < 5'd4)
			return '0;
		return d[4:1] - 4'd1;
	endfunction

endpackage

`default_nettype wire

[rtl/core/dtcc_dp.sv]
`default_nettype none

module dtcc_dp #(
	parameter int MAX_TAIL_BITS = 40
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic [dtcc_pkg::TAIL_W-1:0]   tail_bits,
	input  wire logic [dtcc_pkg::COUNT_W-1:0]  bit_count,
	input  wire dtcc_pkg::dp_cmd_t             cmd,
	output dtcc_pkg::dp_sts_t                  sts,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output dtcc_pkg::status_t                  out_status
);

	localparam logic [dtcc_pkg::COUNT_W-1:0] MAX_C = dtcc_pkg::COUNT_W'(MAX_TAIL_BITS);

	logic [dtcc_pkg::TAIL_W-1:0]  data_q;
	logic [dtcc_pkg::COUNT_W-1:0] rem_q;
	logic [dtcc_pkg::CODE_W-1:0]  code_q;
	logic [dtcc_pkg::NB_W-1:0]    nb_q;
	logic [dtcc_pkg::EXT_W-1:0]   ext_q;
	logic                         bfinal_q;
	logic                         bad_q;
	dtcc_pkg::status_t            res_q;
	dtcc_pkg::status_t            out_status_q;
	logic                         out_valid_q;

	logic [dtcc_pkg::CODE_W-1:0]  code_n;
	logic [dtcc_pkg::NB_W-1:0]    nb_n;
	logic [4:0]                   len_idx;
	dtcc_pkg::sym_kind_t          sym;
	logic [dtcc_pkg::TAIL_W-1:0]  stored_shift;
	logic [31:0]                  stored_word;
	logic [4:0]                   dcode;
	logic [dtcc_pkg::COUNT_W-1:0] ext_wide;

	// next code bit, first stream bit ends up as msb
	assign code_n   = {code_q[dtcc_pkg::CODE_W-2:0], data_q[0]};
	assign nb_n     = nb_q + 4'd1;
	assign ext_wide = {2'b00, ext_q};

	// fixed literal/length code classification
	always_comb begin
		sym     = dtcc_pkg::SYM_NONE;
		len_idx = '0;
		if (nb_n == dtcc_pkg::NB_SHORT && code_n[6:0] <= dtcc_pkg::FIX7_MAX) begin
			len_idx = code_n[4:0] - 5'd1;
			if (code_n[6:0] == 7'd0)
				sym = dtcc_pkg::SYM_EOB;
			else
				sym = dtcc_pkg::SYM_LEN;
		end else if (nb_n == dtcc_pkg::NB_MID &&
				code_n[7:0] inside {[dtcc_pkg::LIT8_LO:dtcc_pkg::LIT8_HI]}) begin
			sym = dtcc_pkg::SYM_LIT;
		end else if (nb_n == dtcc_pkg::NB_MID &&
				code_n[7:0] inside {[dtcc_pkg::LEN8_LO:dtcc_pkg::LEN8_HI]}) begin
			len_idx = dtcc_pkg::LEN8_IDX0 + {2'b00, code_n[2:0]};
			if (len_idx > dtcc_pkg::LEN_IDX_MAX)
				sym = dtcc_pkg::SYM_BAD;
			else
				sym = dtcc_pkg::SYM_LEN;
		end else if (nb_n == dtcc_pkg::NB_LONG) begin
			if (code_n >= dtcc_pkg::LIT9_LO)
				sym = dtcc_pkg::SYM_LIT;
			else
				sym = dtcc_pkg::SYM_BAD;
		end
	end

	// stored block: skip padding, then len and nlen
	always_comb begin
		stored_shift = data_q >> rem_q[2:0];
		stored_word  = stored_shift[31:0];
	end

	// distance code is read msb-first
	assign dcode = {data_q[0], data_q[1], data_q[2], data_q[3], data_q[4]};

	// status toward the controller
	always_comb begin
		sts.count_bad  = bad_q;
		sts.hdr_short  = rem_q < dtcc_pkg::HDR_BITS;
		sts.btype      = dtcc_pkg::btype_t'(data_q[2:1]);
		sts.bfinal     = bfinal_q;
		if (rem_q < dtcc_pkg::STORED_MIN)
			sts.stored_res = dtcc_pkg::STAT_INCOMPLETE;
		else if (stored_word[15:0] != ~stored_word[31:16])
			sts.stored_res = dtcc_pkg::STAT_INVALID;
		else if (stored_word == dtcc_pkg::STORED_EMPTY)
			sts.stored_res = dtcc_pkg::STAT_COMPLETE;
		else
			sts.stored_res = dtcc_pkg::STAT_INCOMPLETE;
		sts.rem_zero   = rem_q == '0;
		sts.sym        = sym;
		sts.ext_short  = rem_q < ext_wide;
		sts.dist_short = rem_q < dtcc_pkg::DIST_BITS;
		sts.dist_bad   = dcode > dtcc_pkg::DIST_MAX;
		sts.out_free   = !out_valid_q || out_ready;
	end

	// bit walk registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			dtcc_pkg::OP_LOAD: begin
				data_q <= tail_bits;
				rem_q  <= bit_count;
				bad_q  <= (bit_count == '0) || (bit_count >= MAX_C);
			end
			dtcc_pkg::OP_HDR: begin
				data_q   <= data_q >> dtcc_pkg::HDR_BITS;
				rem_q    <= rem_q - dtcc_pkg::HDR_BITS;
				bfinal_q <= data_q[0];
				code_q   <= '0;
				nb_q     <= '0;
			end
			dtcc_pkg::OP_CODE: begin
				data_q <= data_q >> 1;
				rem_q  <= rem_q - 6'd1;
				if (sym == dtcc_pkg::SYM_NONE) begin
					code_q <= code_n;
					nb_q   <= nb_n;
				end else begin
					code_q <= '0;
					nb_q   <= '0;
				end
				if (sym == dtcc_pkg::SYM_LEN)
					ext_q <= dtcc_pkg::len_extra(len_idx);
			end
			dtcc_pkg::OP_SKIP: begin
				data_q <= data_q >> ext_q;
				rem_q  <= rem_q - ext_wide;
			end
			dtcc_pkg::OP_DIST: begin
				data_q <= data_q >> dtcc_pkg::DIST_BITS;
				rem_q  <= rem_q - dtcc_pkg::DIST_BITS;
				ext_q  <= dtcc_pkg::dist_extra(dcode);
			end
			default: begin
			end
		endcase
		if (cmd.res_we)
			res_q <= cmd.res;
		if (cmd.out_load)
			out_status_q <= res_q;
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_status = out_status_q;

endmodule

`default_nettype wire

[rtl/core/dtcc_ctrl.sv]
`default_nettype none

module dtcc_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire dtcc_pkg::dp_sts_t   sts,
	output dtcc_pkg::dp_cmd_t        cmd
);

	dtcc_pkg::ctrl_state_t state_q;
	dtcc_pkg::ctrl_state_t state_n;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dtcc_pkg::CS_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	assign in_ready = state_q == dtcc_pkg::CS_IDLE;

	// next state and datapath commands
	always_comb begin
		state_n      = state_q;
		cmd.op       = dtcc_pkg::OP_NOP;
		cmd.res_we   = 1'b0;
		cmd.res      = dtcc_pkg::STAT_INCOMPLETE;
		cmd.out_load = 1'b0;
		case (state_q)
			dtcc_pkg::CS_IDLE: begin
				if (in_valid) begin
					cmd.op  = dtcc_pkg::OP_LOAD;
					state_n = dtcc_pkg::CS_HDR;
				end
			end
			dtcc_pkg::CS_HDR: begin
				if (sts.count_bad || sts.hdr_short) begin
					cmd.res_we = 1'b1;
					cmd.res    = dtcc_pkg::STAT_INCOMPLETE;
					state_n    = dtcc_pkg::CS_DONE;
				end else begin
					cmd.op = dtcc_pkg::OP_HDR;
					case (sts.btype)
						dtcc_pkg::BTYPE_STORED:  state_n = dtcc_pkg::CS_STORED;
						dtcc_pkg::BTYPE_FIXED:   state_n = dtcc_pkg::CS_CODE;
						dtcc_pkg::BTYPE_DYNAMIC: begin
							cmd.res_we = 1'b1;
							cmd.res    = dtcc_pkg::STAT_INCOMPLETE;
							state_n    = dtcc_pkg::CS_DONE;
						end
						default: begin
							cmd.res_we = 1'b1;
							cmd.res    = dtcc_pkg::STAT_INVALID;
							state_n    = dtcc_pkg::CS_DONE;
						end
					endcase
				end
			end
			dtcc_pkg::CS_STORED: begin
				cmd.res_we = 1'b1;
				cmd.res    = sts.stored_res;
				state_n    = dtcc_pkg::CS_DONE;
			end
			dtcc_pkg::CS_CODE: begin
				if (sts.rem_zero) begin
					cmd.res_we = 1'b1;
					cmd.res    = dtcc_pkg::STAT_INCOMPLETE;
					state_n    = dtcc_pkg::CS_DONE;
				end else begin
					cmd.op = dtcc_pkg::OP_CODE;
					case (sts.sym)
						dtcc_pkg::SYM_NONE, dtcc_pkg::SYM_LIT: state_n = dtcc_pkg::CS_CODE;
						dtcc_pkg::SYM_EOB: begin
							if (sts.bfinal) begin
								cmd.res_we = 1'b1;
								cmd.res    = dtcc_pkg::STAT_COMPLETE;
								state_n    = dtcc_pkg::CS_DONE;
							end else begin
								state_n = dtcc_pkg::CS_HDR;
							end
						end
						dtcc_pkg::SYM_LEN: state_n = dtcc_pkg::CS_LEN_EXT;
						default: begin
							cmd.res_we = 1'b1;
							cmd.res    = dtcc_pkg::STAT_INVALID;
							state_n    = dtcc_pkg::CS_DONE;
						end
					endcase
				end
			end
			dtcc_pkg::CS_LEN_EXT, dtcc_pkg::CS_DIST_EXT: begin
				if (sts.ext_short) begin
					cmd.res_we = 1'b1;
					cmd.res    = dtcc_pkg::STAT_INCOMPLETE;
					state_n    = dtcc_pkg::CS_DONE;
				end else begin
					cmd.op = dtcc_pkg::OP_SKIP;
					if (state_q == dtcc_pkg::CS_LEN_EXT)
						state_n = dtcc_pkg::CS_DIST;
					else
						state_n = dtcc_pkg::CS_CODE;
				end
			end
			dtcc_pkg::CS_DIST: begin
				if (sts.dist_short) begin
					cmd.res_we = 1'b1;
					cmd.res    = dtcc_pkg::STAT_INCOMPLETE;
					state_n    = dtcc_pkg::CS_DONE;
				end else if (sts.dist_bad) begin
					cmd.res_we = 1'b1;
					cmd.res    = dtcc_pkg::STAT_INVALID;
					state_n    = dtcc_pkg::CS_DONE;
				end else begin
					cmd.op  = dtcc_pkg::OP_DIST;
					state_n = dtcc_pkg::CS_DIST_EXT;
				end
			end
			dtcc_pkg::CS_DONE: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_n      = dtcc_pkg::CS_IDLE;
				end
			end
			default: state_n = dtcc_pkg::CS_IDLE;
		endcase
	end

endmodule

`default_nettype wire

[rtl/core/deflate_tail_completeness_check_core.sv]
// Deflate tail completeness checker.
// Input stream (s_*): one transaction per request, tail bits and their count.
// The first stream bit sits in bit 0; blocks are walked from there, header
// first, and the walk stops at the end of the first final block, at a
// stored or dynamic block, on invalid input or when bits run out.
// Output stream (m_*): one transaction per request with the status code
// (0 incomplete, 1 complete, 2 invalid).
// After acceptance each block header is checked, fixed codes are walked
// bit by bit and a length/distance pair is taken as length extra bits,
// distance code and distance extra bits. One request is in work at a
// time; the next is taken as soon as the result has moved into the output
// register.
// A stalled receiver holds the result in the output register; a second
// finished result waits in the checker until that register frees up, and
// no new request is taken meanwhile.
// Reset clears the controller and the output valid; no request is lost
// after reset since none is held.
`default_nettype none

module deflate_tail_completeness_check_core #(
	parameter int MAX_TAIL_BITS = 40
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [47:0] s_tdata,  // tail_bits [39:0], bit_count [45:40], zero [47:46]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata   // status [1:0], zero [7:2]
);

	dtcc_pkg::dp_cmd_t cmd;
	dtcc_pkg::dp_sts_t sts;
	dtcc_pkg::status_t out_status;

	// walk sequencing
	dtcc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// bit walk and result register
	dtcc_dp #(
		.MAX_TAIL_BITS (MAX_TAIL_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.tail_bits  (s_tdata[39:0]),
		.bit_count  (s_tdata[45:40]),
		.cmd        (cmd),
		.sts        (sts),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_status (out_status)
	);

	assign m_tdata = {6'b000000, out_status};

endmodule

`default_nettype wire
